/* rtl/oaht_pkg.sv */
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and codes for the linear-probing key/value table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // fixed field widths of the request and response beats
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 64;
    localparam int HASH_W   = 32;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 7;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic CFG_IDX_LOAD_LIMIT = 1'b0;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_SET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GET = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

    // slot states as held in memory
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_LIVE  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    // response status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // load limit
    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 7'd75;
    localparam logic [LIMIT_W-1:0] PERCENT          = 7'd100;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [HASH_W-1:0]  key_hash;
        logic [VALUE_W-1:0] write_value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                new_key;
        logic [VALUE_W-1:0]  read_value;
    } t_rsp;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_RESP
    } t_state;

endpackage

/* rtl/open_addressing_hash_table.sv */
// Flow: an accepted request reads its first slot at its hash index and walks up
// to CAPACITY slots, one per cycle (none for the unused kind), until a hit, a
// vacant slot or the last slot, then stages its result beat for the output
// register; no new request is taken until that beat has been loaded.
// Reset: synchronous; a clearing pass marks every slot empty and holds off
// requests; the load limit returns to 75.
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Fixed-capacity key/value table with linear probing and tombstones, with an
// APB-style register for the insertion load limit.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [oaht_pkg::PADDR_W-1:0]  paddr,
    input  logic [oaht_pkg::PDATA_W-1:0]  pwdata,
    output logic [oaht_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // request channel
    input  logic                          i_in_valid,
    input  oaht_pkg::t_req                i_in_data,
    output logic                          o_in_stall,
    // response channel
    output logic                          o_out_valid,
    output oaht_pkg::t_rsp                o_out_data,
    input  logic                          i_out_stall
);

    import oaht_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY) + 1;

    logic [LIMIT_W-1:0] r_load_limit;
    logic               cfg_wr;
    logic               clearing;
    logic [CNT_W-1:0]   live_count;

    // load limit register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == CFG_IDX_LOAD_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_limit <= LOAD_LIMIT_RESET;
        end else if (cfg_wr) begin
            r_load_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // register readback
    assign prdata = (paddr[2] == CFG_IDX_LOAD_LIMIT) ? PDATA_W'(r_load_limit) : '0;

    oaht_engine #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall),
        .i_load_limit (r_load_limit),
        .o_clearing   (clearing),
        .o_live_count (live_count)
    );

`ifndef SYNTHESIS
    // no request is taken while the slot memory is being cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> o_in_stall)
        else $error("request accepted during clearing pass");

    // live count never exceeds the table capacity
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        live_count <= CNT_W'(CAPACITY))
        else $error("live count above capacity");

    // a fresh insertion is always reported as done
    a_new_key_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.new_key) |-> (o_out_data.status == STATUS_DONE))
        else $error("new key flagged with failing status");

    // a nonzero read value only comes with a successful lookup
    a_value_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.read_value != '0))
            |-> (o_out_data.status == STATUS_DONE) && !o_out_data.new_key)
        else $error("read value on a failed or inserting beat");

    // live count has already settled when an insertion beat first shows
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid && i_out_stall)
            && o_out_data.new_key) |-> (live_count == $past(live_count)))
        else $error("live count changed while staging an insertion beat");
`endif

endmodule

/* rtl/oaht_ram.sv */
// ----------------------------------------------------------------------------
// oaht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/oaht_engine.sv */
// ----------------------------------------------------------------------------
// oaht_engine
// Probe sequencer: clears the slot memory after reset, then walks slots one
// per cycle for each request of a used kind, writing back the slot when a set or delete changes it.
// ----------------------------------------------------------------------------
module oaht_engine #(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  oaht_pkg::t_req                    i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output oaht_pkg::t_rsp                    o_out_data,
    input  logic                              i_out_stall,
    input  logic [oaht_pkg::LIMIT_W-1:0]      i_load_limit,
    output logic                              o_clearing,
    output logic [$clog2(CAPACITY):0]         o_live_count
);

    import oaht_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = IDX_W + 1;
    localparam int LOAD_W = IDX_W + 8;
    localparam int WORD_W = 2 + KEY_BITS + VALUE_BITS;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_n, n_n;
    logic [IDX_W-1:0]      r_tomb, n_tomb;
    logic                  r_tomb_vld, n_tomb_vld;
    logic [CNT_W-1:0]      r_live, n_live;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_rsp, n_rsp;
    t_rsp                  r_out_data;

    // request payload held for the probe
    logic [KIND_W-1:0]     r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_over;

    // memory ports
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;
    logic [WORD_W-1:0]     mem_rdata;

    // slot fields of the word being probed
    logic [1:0]            rd_state;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;

    logic                  in_accept;
    logic                  out_load;
    logic                  kind_ok;
    logic [LOAD_W-1:0]     load_num;
    logic                  load_over;
    logic                  is_live;
    logic                  is_tomb;
    logic                  is_vacant;
    logic                  hit;
    logic                  last;
    logic                  stop;
    logic                  free_vld;
    logic [IDX_W-1:0]      free_idx;

    oaht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_state = mem_rdata[WORD_W-1 -: 2];
    assign rd_key   = mem_rdata[VALUE_BITS +: KEY_BITS];
    assign rd_val   = mem_rdata[VALUE_BITS-1:0];

    // handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == S_RESP) && (!r_out_valid || !i_out_stall);
    assign kind_ok    = (i_in_data.kind == KIND_SET) || (i_in_data.kind == KIND_GET)
                        || (i_in_data.kind == KIND_DEL);

    // load percent before insertion: floor(100 * live / capacity)
    assign load_num  = LOAD_W'(r_live) * LOAD_W'(PERCENT);
    assign load_over = load_num[IDX_W +: 8] > {1'b0, i_load_limit};

    // probe decode of the current slot
    assign is_live   = (rd_state == SLOT_LIVE);
    assign is_tomb   = (rd_state == SLOT_TOMB);
    assign is_vacant = !is_live && !is_tomb;
    assign hit       = is_live && (rd_key == r_key);
    assign last      = &r_n;
    assign stop      = hit || is_vacant || last;
    assign free_vld  = is_vacant || r_tomb_vld || is_tomb;
    assign free_idx  = r_tomb_vld ? r_tomb : r_idx;

    // next state, memory access and response
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_n         = r_n;
        n_tomb      = r_tomb;
        n_tomb_vld  = r_tomb_vld;
        n_live      = r_live;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = {SLOT_EMPTY, (KEY_BITS + VALUE_BITS)'(0)};
        mem_raddr   = r_idx;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_idx  = r_idx + IDX_W'(1);
                if (&r_idx) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                mem_raddr = i_in_data.key_hash[IDX_W-1:0];
                if (in_accept) begin
                    n_idx      = i_in_data.key_hash[IDX_W-1:0];
                    n_n        = '0;
                    n_tomb_vld = 1'b0;
                    if (kind_ok) begin
                        n_state = S_PROBE;
                    end else begin
                        n_rsp   = '{status: STATUS_NOT_FOUND, new_key: 1'b0,
                                    read_value: '0};
                        n_state = S_RESP;
                    end
                end
            end
            S_PROBE: begin
                if (!stop) begin
                    n_idx     = r_idx + IDX_W'(1);
                    n_n       = r_n + IDX_W'(1);
                    mem_raddr = r_idx + IDX_W'(1);
                    if (is_tomb && !r_tomb_vld) begin
                        n_tomb     = r_idx;
                        n_tomb_vld = 1'b1;
                    end
                end else begin
                    n_state = S_RESP;
                    n_rsp   = '{status: STATUS_NOT_FOUND, new_key: 1'b0, read_value: '0};
                    unique case (r_kind)
                        KIND_SET: begin
                            if (hit) begin
                                mem_we       = 1'b1;
                                mem_waddr    = r_idx;
                                mem_wdata    = {SLOT_LIVE, r_key, r_val};
                                n_rsp.status = STATUS_DONE;
                            end else if (r_over || !free_vld) begin
                                n_rsp.status = STATUS_FULL;
                            end else begin
                                mem_we        = 1'b1;
                                mem_waddr     = free_idx;
                                mem_wdata     = {SLOT_LIVE, r_key, r_val};
                                n_live        = r_live + CNT_W'(1);
                                n_rsp.status  = STATUS_DONE;
                                n_rsp.new_key = 1'b1;
                            end
                        end
                        KIND_GET: begin
                            if (hit) begin
                                n_rsp.status     = STATUS_DONE;
                                n_rsp.read_value = VALUE_W'(rd_val);
                            end
                        end
                        KIND_DEL: begin
                            if (hit) begin
                                mem_we       = 1'b1;
                                mem_waddr    = r_idx;
                                mem_wdata    = {SLOT_TOMB, rd_key, rd_val};
                                n_live       = r_live - CNT_W'(r_live != '0);
                                n_rsp.status = STATUS_DONE;
                            end
                        end
                        default: begin
                            n_rsp.status = STATUS_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_n         <= '0;
            r_tomb      <= '0;
            r_tomb_vld  <= 1'b0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_tomb      <= n_tomb;
            r_tomb_vld  <= n_tomb_vld;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    // request payload and load check, captured on accept
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind <= i_in_data.kind;
            r_key  <= i_in_data.key[KEY_BITS-1:0];
            r_val  <= i_in_data.write_value[VALUE_BITS-1:0];
            r_over <= load_over;
        end
    end

    // response staging and output register
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (out_load) begin
            r_out_data <= r_rsp;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_clearing   = (r_state == S_CLEAR);
    assign o_live_count = r_live;

endmodule
